// ===== rtl/assert_macros.svh =====
// ------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/psag_pkg.sv =====
// ------------------------------------------------------------------------
// psag_pkg
// Types and constants of the pointer speed acceleration gain block.
// ------------------------------------------------------------------------
package psag_pkg;

	// Register indexes (byte address bits [3:2])
	localparam logic [1:0] REG_ACCEL_ON  = 2'd0;
	localparam logic [1:0] REG_MAX_GAIN  = 2'd1;
	localparam logic [1:0] REG_KICK_IN   = 2'd2;
	localparam logic [1:0] REG_RAMP      = 2'd3;

	// Register reset values
	localparam logic [15:0] MAX_GAIN_RST = 16'd140;
	localparam logic [15:0] KICK_IN_RST  = 16'd400;
	localparam logic [15:0] RAMP_RST     = 16'd800;

	// Event classes that take acceleration
	localparam logic [1:0] CLS_X = 2'd0;
	localparam logic [1:0] CLS_Y = 2'd1;

	// Time window limit in ms
	localparam logic [48:0] DT_MAX = 49'd1000;

	// Divider step counts
	localparam logic [4:0] SPD_STEPS = 5'd25;
	localparam logic [4:0] T_STEPS   = 5'd7;

	// Unity gain and ramp cap in hundredths
	localparam logic [15:0] GAIN_ONE = 16'd100;
	localparam logic [6:0]  T_CAP    = 7'd100;

	// Reciprocal of 100 for dividends below 2**32: q = (x * DIV100_MAGIC) >> 37
	localparam logic [62:0] DIV100_MAGIC = 63'd1374389535;
	localparam int          DIV100_SHIFT = 37;

	// Sequencer states
	typedef enum logic [10:0] {
		ST_IDLE    = 11'b000_0000_0001,
		ST_DIV_SPD = 11'b000_0000_0010,
		ST_CMP     = 11'b000_0000_0100,
		ST_CAP     = 11'b000_0000_1000,
		ST_DIV_T   = 11'b000_0001_0000,
		ST_GMUL    = 11'b000_0010_0000,
		ST_GDIV    = 11'b000_0100_0000,
		ST_GSET    = 11'b000_1000_0000,
		ST_ODIV    = 11'b001_0000_0000,
		ST_OSET    = 11'b010_0000_0000,
		ST_FIN     = 11'b100_0000_0000
	} state_t;

endpackage

// ===== rtl/pointer_speed_accel_gain.sv =====
// ------------------------------------------------------------------------
// pointer_speed_accel_gain
// Speed dependent gain on pointer motion deltas, bit-serial dividers.
// ------------------------------------------------------------------------
// Channel   Dir  Handshake                   Payload
// event     in   event_valid / event_stall   event_class, delta_in, time_ms
// result    out  result_valid / result_stall delta_out
// config    in   APB write / read            paddr, pwdata, prdata
//
// One transaction at a time. An accelerated event runs 25 restoring divider
// steps for the speed and a compare; above kick-in it adds a cap test, 7 more
// steps for the ramp position when the ramp is not capped, and the states
// GMUL to OSET that multiply and scale; below it the delta passes unchanged.
// The input reopens in the same cycle that the result is presented.
// Pass-through events go from idle straight to the final state. Reset clears
// configuration to defaults and the last motion timestamp to zero. A stalled
// result keeps the sequencer in its final state and event_stall high.
// ------------------------------------------------------------------------
`include "assert_macros.svh"

module pointer_speed_accel_gain
	import psag_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// event channel
	input  logic               event_valid,
	output logic               event_stall,
	input  logic [1:0]         event_class,
	input  logic signed [15:0] delta_in,
	input  logic [47:0]        time_ms,
	// result channel
	output logic               result_valid,
	input  logic               result_stall,
	output logic signed [15:0] delta_out
);

	// Configuration registers
	logic        accel_on_q;
	logic [15:0] max_gain_q;
	logic [15:0] kick_q;
	logic [15:0] ramp_q;

	// Control state
	state_t      state_q;
	logic [4:0]  cnt_q;
	logic [47:0] last_q;
	logic        out_valid_q;

	// Datapath registers
	logic [31:0] dq_q;      // dividend / quotient shift register
	logic [15:0] rem_q;     // partial remainder
	logic [15:0] dvsr_q;    // divisor
	logic        neg_q;
	logic [15:0] mag_q;
	logic [6:0]  t_q;
	logic [31:0] x_q;       // operand of the divide-by-100 unit
	logic [15:0] q_q;       // low quotient bits of the divide-by-100 unit
	logic [15:0] res_q;
	logic [15:0] out_q;

	logic        cfg_wr;
	logic        ev_acc;
	logic        ev_accel;
	logic        fin_go;
	logic [15:0] din_u;
	logic [15:0] mag;
	logic [24:0] num_spd;
	logic [48:0] diff;
	logic [9:0]  dt;
	logic [16:0] trial;
	logic        take;
	logic [15:0] rem_nx;
	logic [24:0] speed;
	logic        spd_gt;
	logic [24:0] over;
	logic [31:0] over_x100;
	logic [22:0] ramp_x101;
	logic        gain_up;
	logic [15:0] gain_dist;
	logic [15:0] gain;
	logic [62:0] mul100;

	// APB access
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		case (paddr[3:2])
			REG_ACCEL_ON: prdata = {31'd0, accel_on_q};
			REG_MAX_GAIN: prdata = {16'd0, max_gain_q};
			REG_KICK_IN:  prdata = {16'd0, kick_q};
			REG_RAMP:     prdata = {16'd0, ramp_q};
			default:      prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_on_q <= 1'b0;
			max_gain_q <= MAX_GAIN_RST;
			kick_q     <= KICK_IN_RST;
			ramp_q     <= RAMP_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_ACCEL_ON: accel_on_q <= pwdata[0];
				REG_MAX_GAIN: max_gain_q <= pwdata[15:0];
				REG_KICK_IN:  kick_q     <= pwdata[15:0];
				REG_RAMP:     ramp_q     <= (pwdata[15:0] == 16'd0) ? 16'd1 : pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Handshakes
	assign event_stall  = (state_q != ST_IDLE);
	assign ev_acc       = event_valid && !event_stall;
	assign ev_accel     = accel_on_q && (event_class == CLS_X || event_class == CLS_Y);
	assign fin_go       = (state_q == ST_FIN) && (!out_valid_q || !result_stall);
	assign result_valid = out_valid_q;
	assign delta_out    = $signed(out_q);

	// Magnitude and counts-times-1000 of the incoming delta
	assign din_u   = delta_in;
	assign mag     = din_u[15] ? (~din_u + 16'd1) : din_u;
	assign num_spd = 25'(mag) * 25'd1000;

	// Elapsed time, forced into 1..1000
	assign diff = {1'b0, time_ms} - {1'b0, last_q};
	always_comb begin
		if (diff[48] || diff == 49'd0) begin
			dt = 10'd1;
		end else if (diff > DT_MAX) begin
			dt = DT_MAX[9:0];
		end else begin
			dt = diff[9:0];
		end
	end

	// One restoring divider step
	assign trial  = {rem_q, dq_q[31]};
	assign take   = (trial >= {1'b0, dvsr_q});
	assign rem_nx = take ? 16'(trial - {1'b0, dvsr_q}) : trial[15:0];

	// Speed over kick-in, scaled by 100, and the ramp cap limit
	assign speed     = dq_q[24:0];
	assign spd_gt    = (speed > 25'(kick_q));
	assign over      = speed - 25'(kick_q);
	assign over_x100 = 32'({over, 6'd0}) + 32'({over, 5'd0}) + 32'({over, 2'd0});
	assign ramp_x101 = 23'({ramp_q, 6'd0}) + 23'({ramp_q, 5'd0}) + 23'({ramp_q, 2'd0})
		+ 23'(ramp_q);

	// Gain step size from the ramp position
	assign gain_up   = (max_gain_q >= GAIN_ONE);
	assign gain_dist = gain_up ? (max_gain_q - GAIN_ONE) : (GAIN_ONE - max_gain_q);
	assign gain      = gain_up ? (GAIN_ONE + q_q) : (GAIN_ONE - q_q);

	// Divide by 100 through the reciprocal
	assign mul100 = 63'(x_q) * DIV100_MAGIC;

	// Sequencer and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= 5'd0;
			last_q      <= 48'd0;
			out_valid_q <= 1'b0;
		end else begin
			// load a finished result, else drop an accepted one
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !result_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (ev_acc) begin
						if (ev_accel) begin
							last_q  <= time_ms;
							cnt_q   <= SPD_STEPS;
							state_q <= ST_DIV_SPD;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_DIV_SPD: begin
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd1) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					state_q <= spd_gt ? ST_CAP : ST_FIN;
				end
				ST_CAP: begin
					if (dq_q >= 32'(ramp_x101)) begin
						state_q <= ST_GMUL;
					end else begin
						cnt_q   <= T_STEPS;
						state_q <= ST_DIV_T;
					end
				end
				ST_DIV_T: begin
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd1) begin
						state_q <= ST_GMUL;
					end
				end
				ST_GMUL: state_q <= ST_GDIV;
				ST_GDIV: state_q <= ST_GSET;
				ST_GSET: state_q <= ST_ODIV;
				ST_ODIV: state_q <= ST_OSET;
				ST_OSET: state_q <= ST_FIN;
				ST_FIN: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (ev_acc) begin
					neg_q   <= din_u[15];
					mag_q   <= mag;
					res_q   <= din_u;
					dvsr_q  <= {6'd0, dt};
					rem_q   <= 16'd0;
					dq_q    <= {num_spd, 7'd0};
				end
			end
			ST_DIV_SPD, ST_DIV_T: begin
				rem_q <= rem_nx;
				dq_q  <= {dq_q[30:0], take};
			end
			ST_CMP: begin
				// hold the scaled excess speed for the cap test
				dq_q <= over_x100;
			end
			ST_CAP: begin
				// below the cap the quotient fits 7 bits: preload the upper part
				t_q    <= T_CAP;
				rem_q  <= dq_q[22:7];
				dq_q   <= {dq_q[6:0], 25'd0};
				dvsr_q <= ramp_q;
			end
			ST_GMUL: begin
				x_q <= 32'(t_q) * 32'(gain_dist);
			end
			ST_GDIV, ST_ODIV: begin
				q_q <= mul100[DIV100_SHIFT +: 16];
			end
			ST_GSET: begin
				x_q <= 32'(mag_q) * 32'(gain);
			end
			ST_OSET: begin
				res_q <= neg_q ? (~q_q + 16'd1) : q_q;
			end
			ST_FIN: begin
				if (fin_go) begin
					out_q <= res_q;
				end
			end
			default: ;
		endcase
		// ramp position comes from the short divide when it ran
		if (state_q == ST_DIV_T && cnt_q == 5'd1) begin
			t_q <= {dq_q[5:0], take};
		end
	end

	// Assertions
	`ASSERT_NEXT(a_busy_after_accept, ev_acc, event_stall,
		"event accepted but block not busy")
	`ASSERT_SAME(a_rem_below_dvsr, (state_q == ST_DIV_SPD || state_q == ST_DIV_T),
		(dvsr_q != 16'd0) && (rem_q < dvsr_q), "divider remainder out of range")
	`ASSERT_NEXT(a_result_loaded, fin_go, result_valid && (out_q == $past(res_q)),
		"finished result not presented")
	`ASSERT_SAME(a_gain_dist_bound, (state_q == ST_GMUL), (t_q <= T_CAP),
		"ramp position above cap")

endmodule
